// ----- hw/rtl/mid_pkg.sv -----
// Shared types and constants for the maximum index difference block.
`timescale 1ns / 1ps

package mid_pkg;

   localparam int VALUE_W = 32;
   localparam int GAP_W = 10;
   localparam int unsigned GAP_MAX = 1023;

   // Control bits that ride with each element down the cell row.
   typedef struct packed {
      logic vld;
      logic done;
      logic last;
      logic found;
   } mid_flags_type;

endpackage

// ----- hw/rtl/max_index_difference.sv -----
// Top level of the maximum index difference block.
//
// Elements arrive on the req_ channel (req_value, req_last), one transfer per
// element; req_last marks the element that closes a sequence. For each closed
// sequence one transfer on the rsp_ channel gives rsp_max_gap, the largest
// j - i with value[i] <= value[j], saturated at 1023. Elements beyond MAX_LEN
// are dropped, though a dropped closing element still closes the sequence.
// Elements flow through a row of MAX_LEN cells, one cell per cycle unless
// the row is frozen; each non-closing element settles in the first free
// cell, and the closing element empties the cells as it passes, so a new
// sequence may follow at once. Throughput: one element per cycle, sustained,
// across sequences, while no result is held under rsp_stall. The result is
// registered in the tail once the closing element has passed every cell.
// Reset empties every cell and the result register.
// While a result waits under rsp_stall the whole row freezes and req_stall is
// raised; nothing is lost.
`timescale 1ns / 1ps

module max_index_difference import mid_pkg::*; #(
   parameter int MAX_LEN = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [GAP_W-1:0]          rsp_max_gap
);

   localparam int DIST_W = $clog2(MAX_LEN);

   logic                      advance;
   mid_flags_type             chain_flags [MAX_LEN+1];
   logic signed [VALUE_W-1:0] chain_value [MAX_LEN+1];
   logic [DIST_W-1:0]         chain_dist  [MAX_LEN+1];

   assign req_stall = !advance;

   assign chain_flags[0] = mid_flags_type'{vld: req_valid, done: 1'b0, last: req_last,
                                           found: 1'b0};
   assign chain_value[0] = req_value;
   assign chain_dist[0]  = '0;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      mid_cell #(
         .DIST_W (DIST_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .flags_i (chain_flags[k]),
         .value_i (chain_value[k]),
         .dist_i  (chain_dist[k]),
         .flags_o (chain_flags[k+1]),
         .value_o (chain_value[k+1]),
         .dist_o  (chain_dist[k+1])
      );
   end

   mid_tail #(
      .DIST_W (DIST_W)
   ) u_tail (
      .clock       (clock),
      .reset       (reset),
      .flags_i     (chain_flags[MAX_LEN]),
      .dist_i      (chain_dist[MAX_LEN]),
      .rsp_stall   (rsp_stall),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_max_gap (rsp_max_gap)
   );

endmodule

// ----- hw/rtl/mid_cell.sv -----
// One cell of the row: holds one element and tests passing elements against it.
`timescale 1ns / 1ps

module mid_cell import mid_pkg::*; #(
   parameter int DIST_W = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  mid_flags_type             flags_i,
   input  logic signed [VALUE_W-1:0] value_i,
   input  logic [DIST_W-1:0]         dist_i,
   output mid_flags_type             flags_o,
   output logic signed [VALUE_W-1:0] value_o,
   output logic [DIST_W-1:0]         dist_o
);

   logic                      full_ff, full_in;
   logic signed [VALUE_W-1:0] stored_ff, stored_in;
   mid_flags_type             flags_ff, flags_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic [DIST_W-1:0]         dist_ff, dist_in;

   always_comb begin
      full_in   = full_ff;
      stored_in = stored_ff;
      flags_in  = flags_i;
      dist_in   = dist_i;
      if (flags_i.vld && !flags_i.done) begin
         if (!full_ff) begin
            // first free cell: the element becomes a token, and settles here unless it closes the sequence
            if (!flags_i.last) begin
               full_in   = 1'b1;
               stored_in = value_i;
            end
            flags_in.done = 1'b1;
            dist_in = flags_i.found ? dist_i + DIST_W'(1) : '0;
         end else begin
            if (flags_i.found) begin
               dist_in = dist_i + DIST_W'(1);
            end else if (stored_ff <= value_i) begin
               flags_in.found = 1'b1;
               dist_in = '0;
            end
            // closing element empties the row behind it
            if (flags_i.last) begin
               full_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         flags_ff <= '0;
      end else if (advance) begin
         full_ff  <= full_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stored_ff <= stored_in;
         value_ff  <= value_i;
         dist_ff   <= dist_in;
      end
   end

   assign flags_o = flags_ff;
   assign value_o = value_ff;
   assign dist_o  = dist_ff;

   a_settle: assert property (@(posedge clock) disable iff (reset)
      advance && flags_i.vld && !flags_i.done && !flags_i.last && !full_ff |=> full_ff)
      else $error("element did not settle in free cell");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      advance && flags_i.vld && !flags_i.done && flags_i.last |=> !full_ff)
      else $error("closing element left cell full");

endmodule

// ----- hw/rtl/mid_tail.sv -----
// End of the row: running maximum of gaps and the result register.
`timescale 1ns / 1ps

module mid_tail import mid_pkg::*; #(
   parameter int DIST_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  mid_flags_type     flags_i,
   input  logic [DIST_W-1:0] dist_i,
   input  logic              rsp_stall,
   output logic              advance,
   output logic              rsp_valid,
   output logic [GAP_W-1:0]  rsp_max_gap
);

   localparam int CMP_W = (DIST_W > GAP_W) ? DIST_W : GAP_W;

   logic [DIST_W-1:0] best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic [DIST_W-1:0] cand;
   logic [DIST_W-1:0] max_val;
   logic [CMP_W-1:0]  max_ext;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // elements that never reached a free cell were beyond the row and count for nothing
      cand    = flags_i.done ? dist_i : '0;
      max_val = (cand > best_ff) ? cand : best_ff;
      max_ext = CMP_W'(max_val);
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      gap_in       = gap_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (flags_i.vld) begin
            if (flags_i.last) begin
               rsp_valid_in = 1'b1;
               gap_in  = (max_ext > CMP_W'(GAP_MAX)) ? GAP_W'(GAP_MAX) : GAP_W'(max_ext);
               best_in = '0;
            end else begin
               best_in = max_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_gap = gap_ff;

   a_close_result: assert property (@(posedge clock) disable iff (reset)
      advance && flags_i.vld && flags_i.last |=> rsp_valid_ff)
      else $error("closing element gave no result");

   a_close_clear: assert property (@(posedge clock) disable iff (reset)
      advance && flags_i.vld && flags_i.last |=> best_ff == '0)
      else $error("running maximum not cleared after result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(best_ff) && rsp_valid_ff)
      else $error("tail state moved while frozen");

endmodule
